/* design/pow2_size_class_allocator_defines.svh */
// Assertion macros used by the checker file of the size-class allocator.
`ifndef POW2_SIZE_CLASS_ALLOCATOR_DEFINES_SVH
`define POW2_SIZE_CLASS_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define P2SCA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define P2SCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/p2sca_pkg.sv */
// Shared constants, codes and types of the power-of-two size-class allocator.
package p2sca_pkg;

	// Fixed field widths.
	localparam int ADDR_BITS  = 20;
	localparam int REQ_W      = 16;
	localparam int NEED_W     = REQ_W + 1;
	localparam int CFG_W      = 9;
	localparam int REG_COUNT  = 8;
	localparam int REG_IDX_W  = 3;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	// Geometry of the size classes.
	localparam int MIN_CLASS_LOG2 = 4;
	localparam int HEADER_BYTES   = 4;

	// Defaults of the top-level parameters.
	localparam int DEF_NUM_CLASSES          = 8;
	localparam int DEF_MAX_BLOCKS_PER_CLASS = 256;

	// Item kinds.
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd3;

	// Verdict of the class test unit for the class under test.
	typedef struct packed {
		logic alloc_hit;
		logic in_range;
		logic aligned;
	} cls_resp_t;

endpackage

/* design/p2sca_store.sv */
// Free-list block store: one write port and one registered read port.
module p2sca_store #(
	parameter int DEPTH = p2sca_pkg::DEF_NUM_CLASSES * p2sca_pkg::DEF_MAX_BLOCKS_PER_CLASS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic [p2sca_pkg::ADDR_BITS-1:0]  wr_data,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic [p2sca_pkg::ADDR_BITS-1:0]  rd_data
);

	logic [p2sca_pkg::ADDR_BITS-1:0] mem_q [DEPTH];
	logic [p2sca_pkg::ADDR_BITS-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/p2sca_class_unit.sv */
// Shared class test unit: block size, fit test, run range and alignment for one class.
module p2sca_class_unit #(
	parameter int NUM_CLASSES          = p2sca_pkg::DEF_NUM_CLASSES,
	parameter int MAX_BLOCKS_PER_CLASS = p2sca_pkg::DEF_MAX_BLOCKS_PER_CLASS
) (
	input  logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] cls,
	input  logic [p2sca_pkg::NEED_W-1:0]                              need,
	input  logic                                                      fill_nz,
	input  logic [p2sca_pkg::ADDR_BITS-1:0]                           blk,
	input  logic [p2sca_pkg::ADDR_BITS-1:0]                           base,
	input  logic [$clog2(MAX_BLOCKS_PER_CLASS + 1)-1:0]               total,
	output logic [p2sca_pkg::ADDR_BITS-1:0]                           block_size,
	output p2sca_pkg::cls_resp_t                                      resp
);

	localparam int SH_W   = $clog2(p2sca_pkg::MIN_CLASS_LOG2 + NUM_CLASSES + 1);
	localparam int SPAN_W = $clog2(MAX_BLOCKS_PER_CLASS + 1) + p2sca_pkg::MIN_CLASS_LOG2 +
			NUM_CLASSES;
	localparam int W1     = (SPAN_W > p2sca_pkg::ADDR_BITS) ? SPAN_W : p2sca_pkg::ADDR_BITS;
	localparam int CMP_W  = (W1 > p2sca_pkg::NEED_W) ? W1 : p2sca_pkg::NEED_W;

	logic [SH_W-1:0]                  shamt;
	logic [CMP_W-1:0]                 bsize;
	logic [CMP_W-1:0]                 span;
	logic [p2sca_pkg::ADDR_BITS-1:0]  off;

	// Block size of the class is a shift by its log2 size.
	assign shamt = SH_W'(p2sca_pkg::MIN_CLASS_LOG2) + SH_W'(cls);
	assign bsize = CMP_W'(1) << shamt;
	assign span  = CMP_W'(total) << shamt;

	// Offset of the block from the start of the class run, wrapping like addresses do.
	assign off = blk - base;

	assign block_size     = p2sca_pkg::ADDR_BITS'(bsize);
	assign resp.alloc_hit = (CMP_W'(need) <= bsize) && fill_nz;
	assign resp.in_range  = CMP_W'(off) < span;
	assign resp.aligned   = (CMP_W'(off) & (bsize - CMP_W'(1))) == '0;

endmodule

/* design/pow2_size_class_allocator.sv */
// Power-of-two size-class allocator: top level with the sequencer and per-class list state.
//
// Allocates and frees blocks of a byte region kept as one FIFO free list per size class;
// class i holds blocks of 2^(4+i) bytes laid out back to back from address zero by an init
// item. Items are taken one at a time: a sequencer walks the classes one per cycle through
// a single shared class test unit (fit test, range compare, alignment check), and touches
// the free-list memory through one write port and one registered read port. An allocate
// scans to the first class that fits and has a free block, reads that class's head entry
// from the store and then loads the result into the output register; a free scans to the
// first class whose run holds the block. Either fails when no class qualifies. A zero-size
// request, an address below the header and the unused kind go straight to the result. An
// init writes one block per cycle and passes over an empty class without a write.
// The output register holds a finished result while the next item is taken.
module pow2_size_class_allocator #(
	parameter int NUM_CLASSES          = p2sca_pkg::DEF_NUM_CLASSES,
	parameter int MAX_BLOCKS_PER_CLASS = p2sca_pkg::DEF_MAX_BLOCKS_PER_CLASS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input items.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [p2sca_pkg::IN_DATA_W-1:0]     s_tdata,  // request_bytes[15:0], free_address[35:16]
	input  logic [p2sca_pkg::MODE_W-1:0]        s_tuser,  // mode[1:0]
	// Result items.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [p2sca_pkg::OUT_DATA_W-1:0]    m_tdata,  // granted_address[19:0]
	output logic [p2sca_pkg::STATUS_W-1:0]      m_tuser,  // status[1:0]
	// Block count registers.
	input  logic                                cfg_wr_en,
	input  logic [p2sca_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [p2sca_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int AW     = p2sca_pkg::ADDR_BITS;
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int IDX_W  = (MAX_BLOCKS_PER_CLASS > 1) ? $clog2(MAX_BLOCKS_PER_CLASS) : 1;
	localparam int TOT_W  = $clog2(MAX_BLOCKS_PER_CLASS + 1);
	localparam int SAT_W  = (TOT_W > p2sca_pkg::CFG_W) ? TOT_W : p2sca_pkg::CFG_W;
	localparam int DEPTH  = NUM_CLASSES * MAX_BLOCKS_PER_CLASS;
	localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// Next position in a ring of MAX_BLOCKS_PER_CLASS entries.
	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
		logic [IDX_W:0] inc;
		inc = {1'b0, p} + (IDX_W + 1)'(1);
		return (inc >= (IDX_W + 1)'(MAX_BLOCKS_PER_CLASS)) ? '0 : inc[IDX_W-1:0];
	endfunction

	// Flat store address of entry idx in the ring of class c.
	function automatic logic [MEM_AW-1:0] ring_addr(input logic [CLS_W-1:0] c,
			input logic [IDX_W-1:0] idx);
		return MEM_AW'(c) * MEM_AW'(MAX_BLOCKS_PER_CLASS) + MEM_AW'(idx);
	endfunction

	logic [2:0]                        state_q;
	logic [CLS_W-1:0]                  cls_q;
	logic                              mode_free_q;
	logic [p2sca_pkg::NEED_W-1:0]      need_q;
	logic [AW-1:0]                     blk_q;
	logic [IDX_W-1:0]                  init_idx_q;
	logic [AW-1:0]                     run_addr_q;
	logic [AW-1:0]                     pend_addr_q;
	logic [p2sca_pkg::STATUS_W-1:0]    pend_status_q;
	logic                              m_tvalid_q;
	logic [AW-1:0]                     out_addr_q;
	logic [p2sca_pkg::STATUS_W-1:0]    out_status_q;

	logic [p2sca_pkg::CFG_W-1:0]       count_q [p2sca_pkg::REG_COUNT];
	logic [IDX_W-1:0]                  head_q  [NUM_CLASSES];
	logic [IDX_W-1:0]                  tail_q  [NUM_CLASSES];
	logic [TOT_W-1:0]                  fill_q  [NUM_CLASSES];
	logic [TOT_W-1:0]                  total_q [NUM_CLASSES];
	logic [AW-1:0]                     base_q  [NUM_CLASSES];

	logic [p2sca_pkg::REQ_W-1:0]       in_req;
	logic [AW-1:0]                     in_faddr;
	logic                              cls_last;
	logic [SAT_W-1:0]                  cnt_ext;
	logic [TOT_W-1:0]                  init_n;
	logic                              init_last_blk;
	logic                              free_ok;
	logic [AW-1:0]                     block_size;
	p2sca_pkg::cls_resp_t              resp;

	logic                              mem_wr_en;
	logic [MEM_AW-1:0]                 mem_wr_addr;
	logic [AW-1:0]                     mem_wr_data;
	logic                              mem_rd_en;
	logic [MEM_AW-1:0]                 mem_rd_addr;
	logic [AW-1:0]                     mem_rd_data;

	// Input fields.
	assign in_req   = s_tdata[p2sca_pkg::REQ_W-1:0];
	assign in_faddr = s_tdata[p2sca_pkg::REQ_W +: AW];

	// Shared class test unit, always looking at the class under the sequencer.
	p2sca_class_unit #(
		.NUM_CLASSES          (NUM_CLASSES),
		.MAX_BLOCKS_PER_CLASS (MAX_BLOCKS_PER_CLASS)
	) u_cls (
		.cls        (cls_q),
		.need       (need_q),
		.fill_nz    (fill_q[cls_q] != '0),
		.blk        (blk_q),
		.base       (base_q[cls_q]),
		.total      (total_q[cls_q]),
		.block_size (block_size),
		.resp       (resp)
	);

	assign cls_last = (cls_q == CLS_W'(NUM_CLASSES - 1));
	assign free_ok  = resp.in_range && resp.aligned && (fill_q[cls_q] < total_q[cls_q]);

	// Block count of the class being laid out, saturated to the ring size.
	assign cnt_ext       = SAT_W'(count_q[p2sca_pkg::REG_IDX_W'(cls_q)]);
	assign init_n        = (cnt_ext > SAT_W'(MAX_BLOCKS_PER_CLASS)) ?
			TOT_W'(MAX_BLOCKS_PER_CLASS) : TOT_W'(cnt_ext);
	assign init_last_blk = (init_n == '0) || (TOT_W'(init_idx_q) == init_n - TOT_W'(1));

	// Free-list store ports.
	assign mem_wr_en   = ((state_q == ST_INIT) && (init_n != '0)) ||
			((state_q == ST_SCAN) && mode_free_q && free_ok);
	assign mem_wr_addr = (state_q == ST_INIT) ? ring_addr(cls_q, init_idx_q) :
			ring_addr(cls_q, tail_q[cls_q]);
	assign mem_wr_data = (state_q == ST_INIT) ? run_addr_q : blk_q;
	assign mem_rd_en   = (state_q == ST_SCAN) && !mode_free_q && resp.alloc_hit;
	assign mem_rd_addr = ring_addr(cls_q, head_q[cls_q]);

	p2sca_store #(
		.DEPTH (DEPTH),
		.AW    (MEM_AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < p2sca_pkg::REG_COUNT; i++) begin
				count_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			count_q[cfg_index] <= cfg_wdata;
		end
	end

	// Sequencer, per-class list state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cls_q         <= '0;
			mode_free_q   <= 1'b0;
			need_q        <= '0;
			blk_q         <= '0;
			init_idx_q    <= '0;
			run_addr_q    <= '0;
			pend_addr_q   <= '0;
			pend_status_q <= p2sca_pkg::STATUS_OK;
			m_tvalid_q    <= 1'b0;
			out_addr_q    <= '0;
			out_status_q  <= p2sca_pkg::STATUS_OK;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				fill_q[i]  <= '0;
				total_q[i] <= '0;
				base_q[i]  <= '0;
			end
		end else begin
			// A taken result empties the output register unless a new one moves in.
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cls_q       <= '0;
						pend_addr_q <= '0;
						case (s_tuser)
							p2sca_pkg::MODE_ALLOC: begin
								if (in_req == '0) begin
									pend_status_q <= p2sca_pkg::STATUS_ZERO;
									state_q       <= ST_DONE;
								end else begin
									need_q      <= p2sca_pkg::NEED_W'(in_req) +
											p2sca_pkg::NEED_W'(p2sca_pkg::HEADER_BYTES);
									mode_free_q <= 1'b0;
									state_q     <= ST_SCAN;
								end
							end
							p2sca_pkg::MODE_FREE: begin
								if (in_faddr < AW'(p2sca_pkg::HEADER_BYTES)) begin
									pend_status_q <= p2sca_pkg::STATUS_BAD_FREE;
									state_q       <= ST_DONE;
								end else begin
									blk_q       <= in_faddr - AW'(p2sca_pkg::HEADER_BYTES);
									mode_free_q <= 1'b1;
									state_q     <= ST_SCAN;
								end
							end
							p2sca_pkg::MODE_INIT: begin
								init_idx_q <= '0;
								run_addr_q <= '0;
								state_q    <= ST_INIT;
							end
							default: begin
								pend_status_q <= p2sca_pkg::STATUS_OK;
								state_q       <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!mode_free_q) begin
						// Allocate: first class that fits and has a free block.
						if (resp.alloc_hit) begin
							head_q[cls_q] <= ring_next(head_q[cls_q]);
							fill_q[cls_q] <= fill_q[cls_q] - TOT_W'(1);
							state_q       <= ST_READ;
						end else if (cls_last) begin
							pend_status_q <= p2sca_pkg::STATUS_OOM;
							state_q       <= ST_DONE;
						end else begin
							cls_q <= cls_q + CLS_W'(1);
						end
					end else begin
						// Free: first class whose run holds the block decides.
						if (resp.in_range) begin
							if (free_ok) begin
								tail_q[cls_q] <= ring_next(tail_q[cls_q]);
								fill_q[cls_q] <= fill_q[cls_q] + TOT_W'(1);
								pend_status_q <= p2sca_pkg::STATUS_OK;
							end else begin
								pend_status_q <= p2sca_pkg::STATUS_BAD_FREE;
							end
							state_q <= ST_DONE;
						end else if (cls_last) begin
							pend_status_q <= p2sca_pkg::STATUS_BAD_FREE;
							state_q       <= ST_DONE;
						end else begin
							cls_q <= cls_q + CLS_W'(1);
						end
					end
				end
				ST_READ: begin
					pend_addr_q   <= mem_rd_data + AW'(p2sca_pkg::HEADER_BYTES);
					pend_status_q <= p2sca_pkg::STATUS_OK;
					state_q       <= ST_DONE;
				end
				ST_INIT: begin
					// First cycle of a class fixes its run and resets its ring.
					if (init_idx_q == '0) begin
						base_q[cls_q]  <= run_addr_q;
						total_q[cls_q] <= init_n;
						head_q[cls_q]  <= '0;
						tail_q[cls_q]  <= (init_n >= TOT_W'(MAX_BLOCKS_PER_CLASS)) ?
								'0 : IDX_W'(init_n);
						fill_q[cls_q]  <= init_n;
					end
					if (init_n != '0) begin
						run_addr_q <= run_addr_q + block_size;
					end
					if (init_last_blk) begin
						init_idx_q <= '0;
						if (cls_last) begin
							pend_status_q <= p2sca_pkg::STATUS_OK;
							state_q       <= ST_DONE;
						end else begin
							cls_q <= cls_q + CLS_W'(1);
						end
					end else begin
						init_idx_q <= init_idx_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_addr_q   <= pend_addr_q;
						out_status_q <= pend_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Handshake and result outputs.
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = p2sca_pkg::OUT_DATA_W'(out_addr_q);
	assign m_tuser  = out_status_q;

endmodule

/* design/p2sca_checker.sv */
// Port-level checks of the size-class allocator, bound to its top level.
`include "pow2_size_class_allocator_defines.svh"

module p2sca_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [p2sca_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [p2sca_pkg::STATUS_W-1:0]    m_tuser
);

	// A stalled result keeps its value.
	`P2SCA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// An accepted item keeps the block busy for at least the next cycle.
	`P2SCA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accepting an item")

	// Only a successful item carries an address.
	`P2SCA_ASSERT_SAME(a_addr_only_ok, m_tvalid && (m_tuser != p2sca_pkg::STATUS_OK), m_tdata[p2sca_pkg::ADDR_BITS-1:0] == '0, "address on a failed result")

	// Padding above the address is zero.
	`P2SCA_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[p2sca_pkg::OUT_DATA_W-1:p2sca_pkg::ADDR_BITS] == '0, "result padding not zero")

endmodule

bind pow2_size_class_allocator p2sca_checker u_p2sca_checker (.*);
